// ===== hdl/x10hb_pkg.sv =====
// Shared types and constants for the X10 half-bit frame receiver.
`default_nettype none

package x10hb_pkg;

	// Width of the reported message field.
	localparam int unsigned MSG_OUT_W = 9;

	// Configuration register width and register indexes.
	localparam int unsigned CFG_W = 4;
	localparam logic CFG_PAUSE_QUIET   = 1'b0;
	localparam logic CFG_RECOVER_QUIET = 1'b1;

	// Register values after reset.
	localparam logic [CFG_W-1:0] PAUSE_QUIET_RESET   = 4'd5;
	localparam logic [CFG_W-1:0] RECOVER_QUIET_RESET = 4'd6;

	// Lead-in closing positions on the first and second copy.
	localparam int unsigned LEADIN_FIRST  = 3;
	localparam int unsigned LEADIN_SECOND = 4;

	// Framing error codes.
	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_LEADIN = 2'd1,
		ERR_DATA   = 2'd2,
		ERR_PAUSE  = 2'd3
	} err_code_t;

	// Result of one half-bit item.
	typedef struct packed {
		logic                 first_copy_done;
		logic                 message_done;
		logic [MSG_OUT_W-1:0] message;
		logic                 copies_differ;
		logic                 error_now;
		err_code_t            last_error;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/x10_half_bit_receiver.sv =====
// Top level of the X10 half-bit frame receiver: configuration, deframer and output register.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  half_bit
//   out      output     out_valid/out_stall  first_copy_done, message_done, message,
//                                            copies_differ, error_now, last_error
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One item is accepted per cycle unless stalled; its result appears in the output register
// on the next cycle, held by the single output register after the deframer logic.
// The input is stalled only while the output register holds a result that is itself stalled.
// Reset clears the deframer to idle and loads the quiet counts with 5 and 6.
`default_nettype none

module x10_half_bit_receiver import x10hb_pkg::*; #(
	parameter int unsigned MESSAGE_BITS = 9
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 half_bit,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      first_copy_done,
	output logic                      message_done,
	output logic [MSG_OUT_W-1:0]      message,
	output logic                      copies_differ,
	output logic                      error_now,
	output logic [1:0]                last_error,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic             accept;
	logic [CFG_W-1:0] pause_quiet_q;
	logic [CFG_W-1:0] recover_quiet_q;
	result_t          result;
	result_t          result_q;
	logic             out_valid_q;

	// Handshake: the output register frees up in the same cycle it is taken.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_quiet_q   <= PAUSE_QUIET_RESET;
			recover_quiet_q <= RECOVER_QUIET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAUSE_QUIET:   pause_quiet_q   <= cfg_data;
				CFG_RECOVER_QUIET: recover_quiet_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	x10hb_deframer #(
		.MESSAGE_BITS(MESSAGE_BITS)
	) u_deframer (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (accept),
		.half_bit           (half_bit),
		.pause_quiet_count  (pause_quiet_q),
		.recover_quiet_count(recover_quiet_q),
		.result             (result)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign first_copy_done = result_q.first_copy_done;
	assign message_done    = result_q.message_done;
	assign message         = result_q.message;
	assign copies_differ   = result_q.copies_differ;
	assign error_now       = result_q.error_now;
	assign last_error      = result_q.last_error;

endmodule

`default_nettype wire

// ===== hdl/x10hb_deframer.sv =====
// Deframing state machine: lead-in check, data pair decode, pause and error recovery.
`default_nettype none

module x10hb_deframer import x10hb_pkg::*; #(
	parameter int unsigned MESSAGE_BITS = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             half_bit,
	input  wire logic [CFG_W-1:0] pause_quiet_count,
	input  wire logic [CFG_W-1:0] recover_quiet_count,
	output result_t               result
);

	localparam int unsigned FRAME_HALVES = 2 * MESSAGE_BITS;
	localparam int unsigned CNT_MAX = (FRAME_HALVES > 31) ? FRAME_HALVES : 31;
	localparam int unsigned CNT_W = $clog2(CNT_MAX + 1);

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_START    = 3'd1,
		PH_DATA     = 3'd2,
		PH_PAUSE    = 3'd3,
		PH_ERROR    = 3'd4,
		PH_SUPPRESS = 3'd5
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
	logic [MESSAGE_BITS-1:0] shift_q, shift_d;
	logic [MESSAGE_BITS-1:0] first_q, first_d;
	logic                    first_pass_q, first_pass_d;
	err_code_t               err_q, err_d;

	logic [MESSAGE_BITS:0]   shift_in;
	logic [MESSAGE_BITS-1:0] msg_word;
	logic [MSG_OUT_W-1:0]    msg_out;
	logic                    first_done, msg_done, differ, err_now;
	logic [CNT_W-1:0]        pause_ext, recover_ext;

	// Saturating half-bit counter and widened quiet thresholds.
	assign cnt_inc     = (cnt_q < CNT_W'(CNT_MAX)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign pause_ext   = CNT_W'(pause_quiet_count);
	assign recover_ext = CNT_W'(recover_quiet_count);
	assign shift_in    = {shift_q, half_bit};

	// Next state and result for the current half-bit.
	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_inc;
		shift_d      = shift_q;
		first_d      = first_q;
		first_pass_d = first_pass_q;
		err_d        = err_q;
		msg_word     = '0;
		first_done   = 1'b0;
		msg_done     = 1'b0;
		differ       = 1'b0;
		err_now      = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				cnt_d = '0;
				if (half_bit) begin
					phase_d      = PH_START;
					err_d        = ERR_NONE;
					first_pass_d = 1'b1;
				end
			end
			PH_START: begin
				if (!half_bit) begin
					if (cnt_inc == (first_pass_q ? CNT_W'(LEADIN_FIRST)
							: CNT_W'(LEADIN_SECOND))) begin
						phase_d = PH_DATA;
						cnt_d   = '0;
						shift_d = '0;
					end else begin
						phase_d = PH_ERROR;
						err_d   = ERR_LEADIN;
						err_now = 1'b1;
					end
				end
			end
			PH_DATA: begin
				// First half of a pair carries the bit; second half must be its complement.
				if (cnt_inc[0] == 1'b0 && shift_q[0] == half_bit) begin
					phase_d = PH_ERROR;
					err_d   = ERR_DATA;
					err_now = 1'b1;
				end else begin
					if (cnt_inc[0]) begin
						shift_d = shift_in[MESSAGE_BITS-1:0];
					end
					if (cnt_inc == CNT_W'(FRAME_HALVES)) begin
						cnt_d = '0;
						if (first_pass_q) begin
							phase_d      = PH_START;
							first_pass_d = 1'b0;
							first_d      = shift_d;
							first_done   = 1'b1;
							msg_word     = shift_d;
							shift_d      = '0;
						end else begin
							phase_d = PH_PAUSE;
						end
					end
				end
			end
			PH_PAUSE: begin
				if (half_bit) begin
					phase_d = PH_ERROR;
					err_d   = ERR_PAUSE;
					err_now = 1'b1;
				end else if (cnt_inc >= pause_ext) begin
					phase_d  = PH_IDLE;
					msg_done = 1'b1;
					msg_word = shift_q;
					differ   = (shift_q != first_q);
				end
			end
			PH_ERROR, PH_SUPPRESS: begin
				// A one restarts the quiet run; the error item itself counts from zero.
				if (half_bit) begin
					cnt_d   = '0;
					phase_d = PH_SUPPRESS;
				end else if (phase_q == PH_ERROR) begin
					cnt_d   = '0;
					phase_d = (recover_ext == '0) ? PH_IDLE : PH_SUPPRESS;
				end else if (cnt_inc >= recover_ext) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Fit the message into the fixed output width.
	generate
		if (MESSAGE_BITS >= MSG_OUT_W) begin : g_msg_trunc
			assign msg_out = msg_word[MSG_OUT_W-1:0];
		end else begin : g_msg_ext
			assign msg_out = {{(MSG_OUT_W - MESSAGE_BITS){1'b0}}, msg_word};
		end
	endgenerate

	assign result.first_copy_done = first_done;
	assign result.message_done    = msg_done;
	assign result.message         = msg_out;
	assign result.copies_differ   = differ;
	assign result.error_now       = err_now;
	assign result.last_error      = err_d;

	// State registers advance once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cnt_q        <= '0;
			shift_q      <= '0;
			first_q      <= '0;
			first_pass_q <= 1'b1;
			err_q        <= ERR_NONE;
		end else if (step) begin
			phase_q      <= phase_d;
			cnt_q        <= cnt_d;
			shift_q      <= shift_d;
			first_q      <= first_d;
			first_pass_q <= first_pass_d;
			err_q        <= err_d;
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_x10_half_bit_receiver.sv =====
// Self-checking testbench for the X10 half-bit frame receiver, with a predicting scoreboard.
`default_nettype none

module tb_x10_half_bit_receiver;
	timeunit 1ns;
	timeprecision 1ps;
	import x10hb_pkg::*;

	localparam int unsigned MESSAGE_BITS = 9;
	localparam int unsigned FRAME_HALVES = 2 * MESSAGE_BITS;
	localparam int unsigned COUNT_TOP = (FRAME_HALVES > 31) ? FRAME_HALVES : 31;
	localparam int unsigned PHASE_ITEMS = 160;
	localparam int unsigned HOLD_CYCLES = 300;

	// Deframer states as the scoreboard tracks them.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_DATA,
		PH_PAUSE,
		PH_ERROR,
		PH_QUIET
	} rx_phase_t;

	// Predicts the result of each accepted half-bit and checks the block's results in order.
	class deframe_checker;
		rx_phase_t               phase;
		int unsigned             count;
		logic [MESSAGE_BITS-1:0] shreg;
		logic [MESSAGE_BITS-1:0] first_copy;
		bit                      first_pass;
		err_code_t               err;
		logic [CFG_W-1:0]        pause_q;
		logic [CFG_W-1:0]        recover_q;
		result_t                 results_due[$];
		int                      mismatches;

		function new();
			phase = PH_IDLE;
			count = 0;
			shreg = '0;
			first_copy = '0;
			first_pass = 1'b1;
			err = ERR_NONE;
			pause_q = PAUSE_QUIET_RESET;
			recover_q = RECOVER_QUIET_RESET;
			mismatches = 0;
		endfunction

		function void set_register(logic idx, logic [CFG_W-1:0] val);
			if (idx == CFG_PAUSE_QUIET) begin
				pause_q = val;
			end else begin
				recover_q = val;
			end
		endfunction

		// Advance the deframer by one half-bit and queue the result it should give.
		function void take_half_bit(logic hb);
			result_t r;
			bit      failed;
			r = '0;
			failed = 1'b0;
			if (count < COUNT_TOP) count++;
			case (phase)
				PH_IDLE: begin
					count = 0;
					if (hb) begin
						phase = PH_LEAD;
						err = ERR_NONE;
						first_pass = 1'b1;
					end
				end
				PH_LEAD: begin
					// The closing zero must land on the right count for this copy.
					if (!hb) begin
						if (count == (first_pass ? LEADIN_FIRST : LEADIN_SECOND)) begin
							phase = PH_DATA;
							count = 0;
							shreg = '0;
						end else begin
							phase = PH_ERROR;
							err = ERR_LEADIN;
							r.error_now = 1'b1;
						end
					end
				end
				PH_DATA: begin
					// Odd halves carry the bit; even halves must be its complement.
					if (count % 2 == 1) begin
						shreg = (shreg << 1) | MESSAGE_BITS'(hb);
					end else if (shreg[0] == hb) begin
						phase = PH_ERROR;
						err = ERR_DATA;
						r.error_now = 1'b1;
						failed = 1'b1;
					end
					if (!failed && count == FRAME_HALVES) begin
						count = 0;
						if (first_pass) begin
							phase = PH_LEAD;
							first_pass = 1'b0;
							first_copy = shreg;
							r.first_copy_done = 1'b1;
							r.message = MSG_OUT_W'(shreg);
							shreg = '0;
						end else begin
							phase = PH_PAUSE;
						end
					end
				end
				PH_PAUSE: begin
					if (hb) begin
						phase = PH_ERROR;
						err = ERR_PAUSE;
						r.error_now = 1'b1;
					end else if (count >= pause_q) begin
						phase = PH_IDLE;
						r.message_done = 1'b1;
						r.message = MSG_OUT_W'(shreg);
						r.copies_differ = (shreg != first_copy);
					end
				end
				PH_ERROR, PH_QUIET: begin
					// Stay silent until enough consecutive quiet half-bits.
					if (phase == PH_ERROR) begin
						phase = PH_QUIET;
						count = 0;
					end
					if (hb) begin
						count = 0;
					end else if (count >= recover_q) begin
						phase = PH_IDLE;
					end
				end
			endcase
			r.last_error = err;
			results_due.push_back(r);
		endfunction

		function void report_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void compare_result(result_t got);
			result_t want;
			if (results_due.size() == 0) begin
				$display("%0t: result with none expected, got %p", $time, got);
				mismatches++;
				return;
			end
			want = results_due.pop_front();
			report_field("first_copy_done", 32'(want.first_copy_done), 32'(got.first_copy_done));
			report_field("message_done", 32'(want.message_done), 32'(got.message_done));
			report_field("message", 32'(want.message), 32'(got.message));
			report_field("copies_differ", 32'(want.copies_differ), 32'(got.copies_differ));
			report_field("error_now", 32'(want.error_now), 32'(got.error_now));
			report_field("last_error", 32'(want.last_error), 32'(got.last_error));
		endfunction

		function int pending();
			return results_due.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 half_bit = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 first_copy_done;
	logic                 message_done;
	logic [MSG_OUT_W-1:0] message;
	logic                 copies_differ;
	logic                 error_now;
	logic [1:0]           last_error;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = CFG_PAUSE_QUIET;
	logic [CFG_W-1:0]     cfg_data = '0;

	deframe_checker deframe = new();
	int unsigned    counted_items = 0;
	bit             tx_idle_on = 1'b0;
	bit             rx_idle_on = 1'b0;
	int             hold_asked = 0;
	int             hold_served = 0;
	int             stall_left = 0;

	x10_half_bit_receiver #(.MESSAGE_BITS(MESSAGE_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.half_bit(half_bit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.first_copy_done(first_copy_done),
		.message_done(message_done),
		.message(message),
		.copies_differ(copies_differ),
		.error_now(error_now),
		.last_error(last_error),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [MESSAGE_BITS-1:0] pick_message();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return MESSAGE_BITS'($urandom());
	endfunction

	// Receiver side: random stalls, plus a long hold when one is asked for.
	always @(posedge clk) begin
		if (hold_asked > hold_served) begin
			hold_served++;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (rx_idle_on && $urandom_range(0, 3) == 0) stall_left = gap_length();
		end
	end

	// Results are sampled mid-cycle, where every signal is settled for the next edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			deframe.compare_result('{first_copy_done, message_done, message, copies_differ,
				error_now, err_code_t'(last_error)});
		end
	end

	// Offer one half-bit item and return at the edge that accepts it.
	task automatic send_half(logic v, bit counted);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		half_bit <= v;
		@(negedge clk);
		while (in_stall) begin
			@(posedge clk);
			@(negedge clk);
		end
		deframe.take_half_bit(v);
		@(posedge clk);
		if (counted) counted_items++;
	endtask

	task automatic send_quiet(int n);
		repeat (n) send_half(1'b0, 1'b1);
	endtask

	// Lead-in: n ones then the closing zero; three ones is a good lead-in.
	task automatic send_lead(int n_ones);
		repeat (n_ones) send_half(1'b1, 1'b1);
		send_half(1'b0, 1'b1);
	endtask

	// One copy of the message as half-bit pairs, first bit first; bad names a broken pair.
	task automatic send_copy(logic [MESSAGE_BITS-1:0] m, int bad);
		int i;
		for (i = MESSAGE_BITS - 1; i >= 0; i--) begin
			send_half(m[i], 1'b1);
			send_half((i == bad) ? m[i] : ~m[i], 1'b1);
		end
	endtask

	task automatic send_random_frame();
		logic [MESSAGE_BITS-1:0] m1;
		logic [MESSAGE_BITS-1:0] m2;
		int                      kind;
		int                      pos;
		int                      bad;
		bit                      on_second;
		m1 = pick_message();
		m2 = ($urandom_range(0, 4) == 0) ? pick_message() : m1;
		kind = $urandom_range(0, 99);
		on_second = $urandom_range(0, 1);
		if (kind < 60) begin
			// Well-formed frame followed by a sufficient pause.
			send_lead(3);
			send_copy(m1, -1);
			send_lead(3);
			send_copy(m2, -1);
			send_quiet(deframe.pause_q + $urandom_range(0, 3));
		end else if (kind < 70) begin
			// Lead-in with too few or too many ones.
			pos = $urandom_range(1, 4);
			if (on_second) begin
				send_lead(3);
				send_copy(m1, -1);
			end
			send_lead(pos < 3 ? pos : pos + 1);
			send_quiet(deframe.recover_q + 2 + $urandom_range(0, 3));
		end else if (kind < 80) begin
			// Equal halves in one pair, often the last one.
			bad = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MESSAGE_BITS - 1);
			if (on_second) begin
				send_lead(3);
				send_copy(m1, -1);
			end
			send_lead(3);
			send_copy(on_second ? m2 : m1, bad);
			send_quiet(deframe.recover_q + 2 + $urandom_range(0, 3));
		end else if (kind < 88) begin
			// Carrier during the pause before delivery.
			send_lead(3);
			send_copy(m1, -1);
			send_lead(3);
			send_copy(m2, -1);
			pos = (deframe.pause_q == 0) ? 0 : $urandom_range(0, deframe.pause_q - 1);
			repeat (pos) send_half(1'b0, 1'b1);
			send_half(1'b1, 1'b1);
			send_quiet(deframe.recover_q + 2 + $urandom_range(0, 3));
		end else if (kind < 93) begin
			// Endless carrier drives the counter into saturation.
			send_lead($urandom_range(32, 45));
			send_quiet(deframe.recover_q + 2 + $urandom_range(0, 3));
		end else begin
			// Line noise, then enough quiet to settle from any state.
			repeat ($urandom_range(10, 30)) send_half($urandom_range(0, 1), 1'b1);
			send_quiet(20 + deframe.recover_q);
		end
	endtask

	// Stop offering items until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (deframe.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_quiet_counts(logic [CFG_W-1:0] pause_val, logic [CFG_W-1:0] recover_val);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PAUSE_QUIET;
		cfg_data <= pause_val;
		deframe.set_register(CFG_PAUSE_QUIET, pause_val);
		@(posedge clk);
		cfg_index <= CFG_RECOVER_QUIET;
		cfg_data <= recover_val;
		deframe.set_register(CFG_RECOVER_QUIET, recover_val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Main sequence: reset, directed lead-in cases, then phases over several settings.
	initial begin
		int p;
		int unsigned phase_end;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short and long lead-ins, each followed by recovery.
		send_lead(2);
		send_quiet(8);
		send_lead(4);
		send_quiet(8);

		for (p = 0; p < 6; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1: write_quiet_counts(4'd0, 4'd0);
					2: write_quiet_counts(4'd15, 4'd15);
					3: write_quiet_counts(4'd1, 4'd15);
					4: write_quiet_counts(4'd15, 4'd0);
					default: write_quiet_counts(CFG_W'($urandom()), CFG_W'($urandom()));
				endcase
			end
			tx_idle_on = (p == 1 || p == 2 || p == 3 || p == 5);
			rx_idle_on = (p == 2 || p == 3 || p == 4 || p == 5);
			// The receiver holds off long enough that the block backs up its input.
			if (p == 3) hold_asked++;
			phase_end = counted_items + PHASE_ITEMS;
			while (counted_items < phase_end) send_random_frame();
		end

		drain();
		repeat (4) @(posedge clk);
		if (deframe.mismatches == 0) begin
			$display("tb_x10_half_bit_receiver: clean");
		end else begin
			$display("tb_x10_half_bit_receiver: errors");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#15_000_000;
		$display("tb_x10_half_bit_receiver: errors");
		$finish;
	end

endmodule

`default_nettype wire
